### rtl/plsl_pkg.sv
// Shared constants, breakpoint tables and types for the sensor linearizer.
package plsl_pkg;

  localparam int NUM_POINTS = 11;
  localparam int SCALE      = 1000;

  localparam int READING_W = 16;
  localparam int VALUE_W   = 15;
  localparam int INDEX_W   = 4;
  localparam int SLOPE_W   = 18;
  localparam int DIFF_W    = READING_W + 1;
  localparam int PROD_W    = SLOPE_W + DIFF_W;
  localparam int NUM_W     = PROD_W + 1;
  localparam int VALUE_MAX = 2 ** VALUE_W - 1;

  // Divide by SCALE as (n * RECIP) >> RECIP_SHIFT, exact for every n below
  // 2**QUO_IN_W. RECIP is ceil(2**35 / 1000); its excess over 2**35 / 1000
  // times 1000 is 632, under 2**(RECIP_SHIFT - QUO_IN_W).
  localparam int QUO_IN_W    = 25;
  localparam int RECIP_SHIFT = 35;
  localparam int RECIP_W     = 26;
  localparam int RECIP       = 34359739;
  localparam int QPROD_W     = QUO_IN_W + RECIP_W;
  localparam int QUO_W       = QPROD_W - RECIP_SHIFT;

  localparam int BP_X [NUM_POINTS] = '{
    1000, 1100, 1250, 1350, 1400, 1600, 1800, 2000, 2600, 4000, 4100
  };
  localparam int BP_Y [NUM_POINTS] = '{
    20000, 8000, 5000, 4000, 3000, 2500, 2000, 1500, 1000, 500, 0
  };

  // Slope of the segment that ends at breakpoint i, scaled by SCALE.
  localparam int SEG_SLOPE [NUM_POINTS] = '{
    0,
    ((BP_Y[1]  - BP_Y[0]) * SCALE) / (BP_X[1]  - BP_X[0]),
    ((BP_Y[2]  - BP_Y[1]) * SCALE) / (BP_X[2]  - BP_X[1]),
    ((BP_Y[3]  - BP_Y[2]) * SCALE) / (BP_X[3]  - BP_X[2]),
    ((BP_Y[4]  - BP_Y[3]) * SCALE) / (BP_X[4]  - BP_X[3]),
    ((BP_Y[5]  - BP_Y[4]) * SCALE) / (BP_X[5]  - BP_X[4]),
    ((BP_Y[6]  - BP_Y[5]) * SCALE) / (BP_X[6]  - BP_X[5]),
    ((BP_Y[7]  - BP_Y[6]) * SCALE) / (BP_X[7]  - BP_X[6]),
    ((BP_Y[8]  - BP_Y[7]) * SCALE) / (BP_X[8]  - BP_X[7]),
    ((BP_Y[9]  - BP_Y[8]) * SCALE) / (BP_X[9]  - BP_X[8]),
    ((BP_Y[10] - BP_Y[9]) * SCALE) / (BP_X[10] - BP_X[9])
  };

  typedef struct packed {
    logic [READING_W-1:0] reading;
    logic [INDEX_W-1:0]   index;
  } plsl_item_t;

endpackage

### rtl/plsl_if.sv
// Handshake channels for raw readings and linearized results.
interface plsl_in_if;
  import plsl_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [READING_W-1:0] reading;
  modport source (output valid, output reading, input ready);
  modport sink   (input valid, input reading, output ready);
endinterface

interface plsl_out_if;
  import plsl_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [VALUE_W-1:0]         distance_value;
  logic [INDEX_W-1:0]         segment_index;
  logic signed [SLOPE_W-1:0]  segment_slope;
  modport source (output valid, output distance_value, output segment_index,
                  output segment_slope, input ready);
  modport sink   (input valid, input distance_value, input segment_index,
                  input segment_slope, output ready);
endinterface

### rtl/piecewise_linear_sensor_linearize_top.sv
// Top level of the piecewise-linear infrared distance linearizer.
// Path inside a segment from the accepting edge to a valid result: queue,
//   multiply, sum, reciprocal multiply by 1/scale, saturate, output; readings
//   at or below the first or past the last breakpoint go straight to output.
// The engine finishes one reading before it takes the next from the queue; a
//   held result beat stalls the engine. Reset (rst, synchronous): empties the
//   queue, idles the engine, drops valid.
module piecewise_linear_sensor_linearize_top (
  input  logic        clk,
  input  logic        rst,
  plsl_in_if.sink     raw,
  plsl_out_if.source  result
);
  import plsl_pkg::*;

  logic       push;
  plsl_item_t push_item;
  logic       queue_full;
  logic       pop;
  logic       pop_valid;
  plsl_item_t pop_item;

  // Front end: classify each beat against the breakpoints and queue it.
  plsl_front u_front (
    .raw        (raw),
    .queue_full (queue_full),
    .push       (push),
    .push_item  (push_item)
  );

  // Short queue: lets the front keep taking beats while the divider runs.
  plsl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_item  (pop_item)
  );

  // Back end: multiply, add, divide by the scale and hold the result beat.
  plsl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_item  (pop_item),
    .pop       (pop),
    .result    (result)
  );

  // At or below the first breakpoint: first table value and no slope.
  a_below_first: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.segment_index == '0) |->
      (result.distance_value == VALUE_W'(BP_Y[0])) && (result.segment_slope == '0))
    else $error("below-first result is wrong");

  // Past the last breakpoint: last table value and no slope.
  a_past_last: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.segment_index == INDEX_W'(NUM_POINTS)) |->
      (result.distance_value == VALUE_W'(BP_Y[NUM_POINTS-1])) &&
      (result.segment_slope == '0))
    else $error("past-last result is wrong");

  // A valid result never names a segment beyond the table.
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (int'(result.segment_index) <= NUM_POINTS))
    else $error("segment index out of range");

endmodule

### rtl/plsl_queue.sv
// Two-entry queue between the classifier and the interpolation engine.
module plsl_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  plsl_pkg::plsl_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output logic                 pop_valid,
  output plsl_pkg::plsl_item_t pop_item
);
  import plsl_pkg::*;

  plsl_item_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### rtl/plsl_front.sv
// Front end: accept readings and find the breakpoint segment of each one.
module plsl_front (
  plsl_in_if.sink              raw,
  input  logic                 queue_full,
  output logic                 push,
  output plsl_pkg::plsl_item_t push_item
);
  import plsl_pkg::*;

  logic [INDEX_W-1:0] index;

  // First breakpoint whose reading is at least the input; NUM_POINTS if none.
  always_comb begin
    index = INDEX_W'(NUM_POINTS);
    for (int i = NUM_POINTS - 1; i >= 0; i--) begin
      if (int'(raw.reading) <= BP_X[i]) index = INDEX_W'(i);
    end
  end

  assign raw.ready         = ~queue_full;
  assign push              = raw.valid & ~queue_full;
  assign push_item.reading = raw.reading;
  assign push_item.index   = index;

endmodule

### rtl/plsl_back.sv
// Back end: interpolate one segment and divide by the scale with a reciprocal multiply.
module plsl_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pop_valid,
  input  plsl_pkg::plsl_item_t pop_item,
  output logic                 pop,
  plsl_out_if.source           result
);
  import plsl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_LOAD, S_DIV, S_SAT, S_DONE
  } state_t;

  state_t                     state;
  logic [INDEX_W-1:0]         index_r;
  logic [DIFF_W-1:0]          diff;
  logic signed [SLOPE_W-1:0]  slope_r;
  logic signed [NUM_W-1:0]    base;
  logic signed [PROD_W-1:0]   prod;
  logic [QUO_IN_W-1:0]        dvd;
  logic [QPROD_W-1:0]         qprod;
  logic [VALUE_W-1:0]         value_r;

  logic                       seg_mid;
  logic [INDEX_W-1:0]         lo;
  int                         x0;
  int                         y0;
  int                         sl;
  logic signed [NUM_W-1:0]    num;
  logic [QUO_W-1:0]           quo;

  // Look up the lower breakpoint and the segment slope for the head item.
  always_comb begin
    seg_mid = (pop_item.index != '0) && (int'(pop_item.index) < NUM_POINTS);
    if (seg_mid) begin
      lo = pop_item.index - 1'b1;
    end else if (pop_item.index == '0) begin
      lo = '0;
    end else begin
      lo = INDEX_W'(NUM_POINTS - 1);
    end
    x0 = BP_X[lo];
    y0 = BP_Y[lo];
    sl = seg_mid ? SEG_SLOPE[pop_item.index] : 0;
  end

  assign pop = (state == S_IDLE) && pop_valid;
  assign num = base + NUM_W'(prod);
  assign quo = qprod[QPROD_W-1:RECIP_SHIFT];

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result.valid <= 1'b0;
    end else begin
      // Drop valid once the beat is taken, unless a new beat replaces it now.
      if (result.valid && result.ready && state != S_DONE) result.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (pop_valid) begin
            index_r <= pop_item.index;
            slope_r <= SLOPE_W'(sl);
            diff    <= DIFF_W'(int'(pop_item.reading) - x0);
            base    <= NUM_W'(y0 * SCALE);
            value_r <= VALUE_W'(y0);
            state   <= seg_mid ? S_MUL : S_DONE;
          end
        end
        S_MUL: begin
          prod  <= PROD_W'(slope_r) * PROD_W'($signed({1'b0, diff}));
          state <= S_LOAD;
        end
        S_LOAD: begin
          // Negative numerators truncate to zero or below: clamp at zero.
          if (num[NUM_W-1]) begin
            value_r <= '0;
            state   <= S_DONE;
          end else if (num[NUM_W-2:QUO_IN_W] != '0) begin
            // Quotient is past the distance field: saturate now.
            value_r <= VALUE_W'(VALUE_MAX);
            state   <= S_DONE;
          end else begin
            dvd   <= num[QUO_IN_W-1:0];
            state <= S_DIV;
          end
        end
        S_DIV: begin
          qprod <= QPROD_W'(dvd) * QPROD_W'(RECIP);
          state <= S_SAT;
        end
        S_SAT: begin
          value_r <= (quo > QUO_W'(VALUE_MAX)) ? VALUE_W'(VALUE_MAX) : VALUE_W'(quo);
          state   <= S_DONE;
        end
        S_DONE: begin
          if (!result.valid || result.ready) begin
            result.valid          <= 1'b1;
            result.distance_value <= value_r;
            result.segment_index  <= index_r;
            result.segment_slope  <= slope_r;
            state                 <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
